// ----- src/aavr_pkg.sv -----
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared widths, constants and helper functions of the axis-angle rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int VEC_W           = 32;
  localparam int ANGLE_W         = 16;
  localparam int ATAN_COUNT      = 32;
  localparam int NORM_STEPS      = 5;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_STEPS       = 31;
  localparam int POST_STAGES     = 4;
  localparam int TRIG_STAGES_DEF = 16;

  localparam logic signed [32:0] INV_GAIN  = 33'sd652032874;
  localparam logic signed [32:0] UNIT_ONE  = 33'sd1073741824;
  localparam logic signed [32:0] DOT_LIMIT = 33'sd3758096384;

  typedef logic signed [VEC_W-1:0] comp_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // round to nearest, ties up, then drop 30 fraction bits
  function automatic logic signed [41:0] rnd30(input logic signed [71:0] v);
    logic signed [71:0] t;
    t = (v + 72'sd536870912) >>> 30;
    return 42'(t);
  endfunction

endpackage

// ----- src/aavr_delay.sv -----
// ----------------------------------------------------------------------------
// aavr_delay
// Enabled shift line that carries side data along the pipeline.
// ----------------------------------------------------------------------------
module aavr_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ----- src/aavr_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// aavr_sqrt_cell
// One digit step of the 64-bit integer square root.
// ----------------------------------------------------------------------------
module aavr_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_in,
  input  logic [63:0] res_in,
  output logic [63:0] n_out,
  output logic [63:0] res_out
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;

  assign trial = res_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= trial) begin
        n_out   <= n_in - trial;
        res_out <= (res_in >> 1) + BIT;
      end else begin
        n_out   <= n_in;
        res_out <= res_in >> 1;
      end
    end
  end

endmodule

// ----- src/aavr_div_cell.sv -----
// ----------------------------------------------------------------------------
// aavr_div_cell
// One quotient bit of the three-lane axis normalization divide.
// ----------------------------------------------------------------------------
module aavr_div_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [31:0]                          mag_in,
  input  logic [2:0][32:0]                     rem_in,
  input  logic [2:0][aavr_pkg::DIV_STEPS-1:0]  q_in,
  output logic [31:0]                          mag_out,
  output logic [2:0][32:0]                     rem_out,
  output logic [2:0][aavr_pkg::DIV_STEPS-1:0]  q_out
);

  logic [2:0][32:0] t;
  logic [2:0]       ge;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      t[l]  = FIRST ? rem_in[l] : {rem_in[l][31:0], 1'b0};
      ge[l] = t[l] >= {1'b0, mag_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_out <= mag_in;
      for (int l = 0; l < 3; l++) begin
        rem_out[l] <= ge[l] ? t[l] - {1'b0, mag_in} : t[l];
        q_out[l]   <= {q_in[l][aavr_pkg::DIV_STEPS-2:0], ge[l]};
      end
    end
  end

endmodule

// ----- src/aavr_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// aavr_cordic_cell
// One rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module aavr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] x_in,
  input  logic signed [32:0] y_in,
  input  logic signed [33:0] z_in,
  input  logic               neg_in,
  output logic signed [32:0] x_out,
  output logic signed [32:0] y_out,
  output logic signed [33:0] z_out,
  output logic               neg_out
);

  localparam logic signed [33:0] ATAN = $signed({2'b00, aavr_pkg::atan_turn(5'(IDX))});

  always_ff @(posedge clk) begin
    if (en) begin
      neg_out <= neg_in;
      if (!z_in[33]) begin
        x_out <= x_in - (y_in >>> IDX);
        y_out <= y_in + (x_in >>> IDX);
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + (y_in >>> IDX);
        y_out <= y_in - (x_in >>> IDX);
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule

// ----- src/aavr_combine.sv -----
// ----------------------------------------------------------------------------
// aavr_combine
// Cross and dot products and the Rodrigues sum, four registered stages.
// ----------------------------------------------------------------------------
module aavr_combine (
  input  logic            clk,
  input  logic            en,
  input  aavr_pkg::comp_t v [3],
  input  aavr_pkg::comp_t k [3],
  input  aavr_pkg::comp_t c,
  input  aavr_pkg::comp_t s,
  input  logic            zero,
  output aavr_pkg::comp_t r [3],
  output logic            zero_out
);

  // stage A
  logic signed [63:0] kv [3][3];
  logic signed [63:0] vc [3];
  logic signed [64:0] kom [3];
  aavr_pkg::comp_t    sa;
  aavr_pkg::comp_t    va [3];
  logic               za;
  logic signed [32:0] omc;

  // stage B
  logic signed [34:0] kxv [3];
  logic signed [32:0] dpb;
  logic signed [33:0] ub [3];
  logic signed [33:0] rvc [3];
  aavr_pkg::comp_t    sb;
  aavr_pkg::comp_t    vb [3];
  logic               zb;
  logic signed [41:0] dp_w;
  logic signed [32:0] dp_c;

  // stage C
  logic signed [66:0] pks [3];
  logic signed [66:0] pdu [3];
  logic signed [33:0] rvcc [3];
  aavr_pkg::comp_t    vcc [3];
  logic               zc;

  logic signed [41:0] sum_w [3];
  aavr_pkg::comp_t    sat_w [3];

  assign omc = aavr_pkg::UNIT_ONE - 33'(c);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          kv[i][j] <= k[i] * v[j];
        end
        vc[i]  <= v[i] * c;
        kom[i] <= k[i] * omc;
        va[i]  <= v[i];
      end
      sa <= s;
      za <= zero;
    end
  end

  assign dp_w = aavr_pkg::rnd30(72'(kv[0][0]) + 72'(kv[1][1]) + 72'(kv[2][2]));

  always_comb begin
    if (dp_w > aavr_pkg::DOT_LIMIT) begin
      dp_c = aavr_pkg::DOT_LIMIT;
    end else if (dp_w < -aavr_pkg::DOT_LIMIT) begin
      dp_c = -aavr_pkg::DOT_LIMIT;
    end else begin
      dp_c = 33'(dp_w);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kxv[0] <= 35'(aavr_pkg::rnd30(72'(kv[1][2]) - 72'(kv[2][1])));
      kxv[1] <= 35'(aavr_pkg::rnd30(72'(kv[2][0]) - 72'(kv[0][2])));
      kxv[2] <= 35'(aavr_pkg::rnd30(72'(kv[0][1]) - 72'(kv[1][0])));
      for (int i = 0; i < 3; i++) begin
        ub[i]  <= 34'(aavr_pkg::rnd30(72'(kom[i])));
        rvc[i] <= 34'(aavr_pkg::rnd30(72'(vc[i])));
        vb[i]  <= va[i];
      end
      dpb <= dp_c;
      sb  <= sa;
      zb  <= za;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pks[i]  <= kxv[i] * sb;
        pdu[i]  <= dpb * ub[i];
        rvcc[i] <= rvc[i];
        vcc[i]  <= vb[i];
      end
      zc <= zb;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_w[i] = 42'(rvcc[i]) + aavr_pkg::rnd30(72'(pks[i])) + aavr_pkg::rnd30(72'(pdu[i]));
      if (sum_w[i] > 42'sd2147483647) begin
        sat_w[i] = 32'sh7fffffff;
      end else if (sum_w[i] < -42'sd2147483648) begin
        sat_w[i] = 32'sh80000000;
      end else begin
        sat_w[i] = 32'(sum_w[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r[i] <= zc ? vcc[i] : sat_w[i];
      end
      zero_out <= zc;
    end
  end

endmodule

// ----- src/axis_angle_vector_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_unit
// Rotates a Q16.16 vector about an arbitrary axis by a binary angle.
// ----------------------------------------------------------------------------
// Slave channel s_*: one request per beat holds vector, axis and angle.
// Master channel m_*: the rotated vector, saturated per component, with
// m_tuser set when the axis was all zero (vector then passes unchanged).
// Throughput: one request per cycle while the chain advances (see Stall).
// Pipeline: from input to output register the depth is set by the axis
// path: max and prescale (6), squares and sum (2), a 32-cell square-root
// chain, a 31-cell divide chain and 4 product/sum stages.
// The sine/cosine CORDIC chain (TRIG_STAGES cells, capped at ATAN_COUNT)
// runs beside the axis path, fed through a matching angle delay line.
// Stall: the whole chain advances only while the output register is empty
// or being taken; s_tready follows that condition, so nothing is dropped.
// Reset: rst clears all valid flags; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_unit #(
  parameter int TRIG_STAGES = aavr_pkg::TRIG_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  logic [207:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x, out_y, out_z
  output logic [95:0]  m_tdata,
  // zero_axis
  output logic         m_tuser
);

  localparam int CORDIC_N  = (TRIG_STAGES > aavr_pkg::ATAN_COUNT) ?
                             aavr_pkg::ATAN_COUNT : TRIG_STAGES;
  localparam int AXIS_LAT  = 1 + aavr_pkg::NORM_STEPS + 2 + aavr_pkg::SQRT_STEPS +
                             aavr_pkg::DIV_STEPS;
  localparam int ANGLE_LAT = AXIS_LAT - CORDIC_N - 1;
  localparam int TOTAL_LAT = AXIS_LAT + aavr_pkg::POST_STAGES;
  localparam int QW        = aavr_pkg::DIV_STEPS;

  logic                 adv;
  logic [TOTAL_LAT-1:0] vld;

  aavr_pkg::comp_t      ain [3];
  logic [31:0]          mabs [3];
  logic [31:0]          top0;
  logic [2:0]           neg_in;
  logic                 zero_in;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL_LAT-2:0], s_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ain[i]    = s_tdata[96+32*i +: 32];
      mabs[i]   = ain[i][31] ? (~ain[i] + 32'd1) : ain[i];
      neg_in[i] = ain[i][31];
    end
    top0 = mabs[0];
    if (mabs[1] > top0) top0 = mabs[1];
    if (mabs[2] > top0) top0 = mabs[2];
    zero_in = (top0 == 32'd0);
  end

  // prescale: shift all magnitudes together until the largest reaches 2^30
  logic [31:0] nm   [aavr_pkg::NORM_STEPS+1][3];
  logic [31:0] ntop [aavr_pkg::NORM_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) nm[0][i] <= mabs[i];
      ntop[0] <= top0;
    end
  end

  for (genvar g = 0; g < aavr_pkg::NORM_STEPS; g++) begin : g_norm
    localparam int SH = 16 >> g;
    logic do_sh;
    assign do_sh = ntop[g] < (32'd1 << (31 - SH));
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) nm[g+1][i] <= do_sh ? nm[g][i] << SH : nm[g][i];
      end
    end
    if (g < aavr_pkg::NORM_STEPS - 1) begin : g_top
      always_ff @(posedge clk) begin
        if (adv) ntop[g+1] <= do_sh ? ntop[g] << SH : ntop[g];
      end
    end
  end

  logic [63:0] sq [3];
  logic [63:0] sq_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= nm[aavr_pkg::NORM_STEPS][i] * nm[aavr_pkg::NORM_STEPS][i];
      end
      sq_sum <= sq[0] + sq[1] + sq[2];
    end
  end

  logic [63:0] sn [aavr_pkg::SQRT_STEPS+1];
  logic [63:0] sr [aavr_pkg::SQRT_STEPS+1];

  assign sn[0] = sq_sum;
  assign sr[0] = 64'd0;

  for (genvar g = 0; g < aavr_pkg::SQRT_STEPS; g++) begin : g_sqrt
    aavr_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(adv), .n_in(sn[g]), .res_in(sr[g]),
      .n_out(sn[g+1]), .res_out(sr[g+1])
    );
  end

  logic [95:0] m_d;

  aavr_delay #(.WIDTH(96), .DEPTH(2 + aavr_pkg::SQRT_STEPS)) u_mag_dly (
    .clk(clk), .en(adv),
    .din({nm[aavr_pkg::NORM_STEPS][2], nm[aavr_pkg::NORM_STEPS][1],
          nm[aavr_pkg::NORM_STEPS][0]}),
    .dout(m_d)
  );

  logic [31:0]          dm [aavr_pkg::DIV_STEPS+1];
  logic [2:0][32:0]     dr [aavr_pkg::DIV_STEPS+1];
  logic [2:0][QW-1:0]   dq [aavr_pkg::DIV_STEPS+1];

  assign dm[0] = sr[aavr_pkg::SQRT_STEPS][31:0];
  assign dr[0] = {1'b0, m_d[95:64], 1'b0, m_d[63:32], 1'b0, m_d[31:0]};
  assign dq[0] = '0;

  for (genvar g = 0; g < aavr_pkg::DIV_STEPS; g++) begin : g_div
    aavr_div_cell #(.FIRST(g == 0)) u_cell (
      .clk(clk), .en(adv),
      .mag_in(dm[g]), .rem_in(dr[g]), .q_in(dq[g]),
      .mag_out(dm[g+1]), .rem_out(dr[g+1]), .q_out(dq[g+1])
    );
  end

  // vector, axis signs and zero flag ride beside the axis path
  logic [99:0] side_d;
  logic        jzero;
  logic [2:0]  jneg;

  aavr_delay #(.WIDTH(100), .DEPTH(AXIS_LAT)) u_vec_dly (
    .clk(clk), .en(adv),
    .din({zero_in, neg_in, s_tdata[95:0]}),
    .dout(side_d)
  );

  assign jzero = side_d[99];
  assign jneg  = side_d[98:96];

  // angle path
  logic [15:0] ang_d;
  logic [31:0] phase;
  logic [31:0] phase_f;
  logic        fold;

  aavr_delay #(.WIDTH(16), .DEPTH(ANGLE_LAT)) u_ang_dly (
    .clk(clk), .en(adv), .din(s_tdata[207:192]), .dout(ang_d)
  );

  assign phase   = {ang_d, 16'd0};
  assign fold    = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
  assign phase_f = fold ? (phase ^ 32'h8000_0000) : phase;

  logic signed [32:0] cx [CORDIC_N+1];
  logic signed [32:0] cy [CORDIC_N+1];
  logic signed [33:0] cz [CORDIC_N+1];
  logic               cn [CORDIC_N+1];

  assign cx[0] = aavr_pkg::INV_GAIN;
  assign cy[0] = 33'sd0;
  assign cz[0] = 34'($signed(phase_f));
  assign cn[0] = fold;

  for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
    aavr_cordic_cell #(.IDX(g)) u_cell (
      .clk(clk), .en(adv),
      .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]), .neg_in(cn[g]),
      .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1]), .neg_out(cn[g+1])
    );
  end

  function automatic aavr_pkg::comp_t clamp_unit(input logic signed [32:0] v,
                                                 input logic neg);
    logic signed [32:0] t;
    t = neg ? -v : v;
    if (t > aavr_pkg::UNIT_ONE) return 32'(aavr_pkg::UNIT_ONE);
    if (t < -aavr_pkg::UNIT_ONE) return 32'(-aavr_pkg::UNIT_ONE);
    return 32'(t);
  endfunction

  aavr_pkg::comp_t cos_r;
  aavr_pkg::comp_t sin_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r <= clamp_unit(cx[CORDIC_N], cn[CORDIC_N]);
      sin_r <= clamp_unit(cy[CORDIC_N], cn[CORDIC_N]);
    end
  end

  // join
  aavr_pkg::comp_t jv [3];
  aavr_pkg::comp_t jk [3];
  aavr_pkg::comp_t ro [3];
  logic [QW-1:0]   qf [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qf[i] = dq[aavr_pkg::DIV_STEPS][i];
      jv[i] = side_d[32*i +: 32];
      jk[i] = jneg[i] ? -$signed({1'b0, qf[i]}) : $signed({1'b0, qf[i]});
    end
  end

  aavr_combine u_combine (
    .clk(clk), .en(adv), .v(jv), .k(jk), .c(cos_r), .s(sin_r), .zero(jzero),
    .r(ro), .zero_out(m_tuser)
  );

  assign m_tdata = {ro[2], ro[1], ro[0]};

  logic join_ok;
  assign join_ok = vld[AXIS_LAT-1] && !jzero;

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    join_ok |-> (dm[aavr_pkg::DIV_STEPS][31:30] != 2'b00))
    else $error("axis length out of range after prescale");

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    join_ok |-> (qf[0] <= 31'd1073741824) && (qf[1] <= 31'd1073741824) &&
                (qf[2] <= 31'd1073741824))
    else $error("unit axis component above one");

  a_unit_major: assert property (@(posedge clk) disable iff (rst)
    join_ok |-> (qf[0] >= 31'd536870912) || (qf[1] >= 31'd536870912) ||
                (qf[2] >= 31'd536870912))
    else $error("unit axis has no major component");

endmodule
